@@ sv/ltfp_pkg.sv @@
// package: transfer types, record and status codes for the location tlv frame parser
package ltfp_pkg;

    // anchor records parsed per frame at most
    localparam logic [7:0] MAX_ANCHORS = 8'd14;

    // record kinds
    localparam logic [1:0] KIND_SELF   = 2'd0;
    localparam logic [1:0] KIND_ANCHOR = 2'd1;
    localparam logic [1:0] KIND_TAG    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_TOO_MANY  = 3'd4;

    // distance type codes
    localparam logic [1:0] DT_NONE    = 2'd0;
    localparam logic [1:0] DT_ANCHOR  = 2'd1;
    localparam logic [1:0] DT_TAG     = 2'd2;
    localparam logic [1:0] DT_UNKNOWN = 2'd3;

    // type bytes in the frame
    localparam logic [7:0] TYPE_POS     = 8'h41;
    localparam logic [7:0] TYPE_DIST    = 8'h48;
    localparam logic [7:0] TYPE_POSDIST = 8'h49;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         record_kind;
        logic [15:0]        node_id;
        logic [31:0]        range_mm;
        logic [7:0]         range_quality;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]         pos_quality;
        logic [2:0]         frame_status;
        logic               last_of_run;
    } t_out_item;

endpackage

@@ sv/location_tlv_frame_parser_unit.sv @@
// top level: byte-wise location response frame parser with a four-entry result queue
//
// The parser takes one frame byte per clock while o_stall is low and updates its offset
// counter and field accumulators in the same cycle the byte is transferred. Each byte makes
// zero, one or two results (a completed record and, on the final byte, the frame status);
// these go into a four-entry result queue that drains one result per clock while the
// receiver does not stall. Input stall is raised while fewer than two queue entries are
// free, so a byte that makes two results may stall the input until the queue drains.
// Results are registered in the queue and leave it in the order they were made. A frame
// whose status is not ok carries records that the consumer should drop.
module location_tlv_frame_parser_unit
    import ltfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    // frame offsets of fixed fields
    localparam logic [8:0] OFF_POS_TYPE  = 9'd3;
    localparam logic [8:0] OFF_POS_FIRST = 9'd5;
    localparam logic [8:0] OFF_POS_LAST  = 9'd16;
    localparam logic [8:0] OFF_POS_QUAL  = 9'd17;
    localparam logic [8:0] OFF_DIST_TYPE = 9'd18;
    localparam logic [8:0] OFF_COUNT     = 9'd20;
    localparam logic [8:0] OFF_REC_START = 9'd21;
    localparam logic [8:0] OFF_MAX       = 9'd511;

    // record byte positions
    localparam logic [4:0] RB_ID_END    = 5'd2;
    localparam logic [4:0] RB_A_RNG_LO  = 5'd8;
    localparam logic [4:0] RB_A_RNG_HI  = 5'd11;
    localparam logic [4:0] RB_A_QUAL    = 5'd12;
    localparam logic [4:0] RB_T_RNG_LO  = 5'd2;
    localparam logic [4:0] RB_T_RNG_HI  = 5'd5;
    localparam logic [4:0] RB_T_RQUAL   = 5'd6;
    localparam logic [4:0] RB_T_POS_LO  = 5'd7;
    localparam logic [4:0] RB_T_POS_HI  = 5'd18;
    localparam logic [4:0] RB_T_PQUAL   = 5'd19;

    // parser state
    logic [8:0]  r_off, n_off;
    logic [1:0]  r_dtype, n_dtype;
    logic [7:0]  r_total, n_total;
    logic [7:0]  r_idx, n_idx;
    logic [4:0]  r_rb, n_rb;
    logic [15:0] r_id, n_id;
    logic [31:0] r_rng, n_rng;
    logic [31:0] r_coord [3];
    logic [31:0] n_coord [3];
    logic [7:0]  r_qhold, n_qhold;
    logic [2:0]  r_err, n_err;
    logic        r_self, n_self;

    // result queue
    t_out_item   r_q [4];
    logic [1:0]  r_wr, r_rd;
    logic [2:0]  r_cnt;

    logic        in_xfer, out_xfer;
    logic [7:0]  b;
    logic        rec_vld;
    t_out_item   rec;
    t_out_item   sts;
    logic [8:0]  off_m5;
    logic [4:0]  rb_m7;
    logic [1:0]  ci;
    logic [7:0]  lim_cur, lim_next;
    logic [2:0]  st;

    assign b        = i_data.data_byte;
    assign o_stall  = (r_cnt > 3'd2);
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = (r_cnt != 3'd0);
    assign out_xfer = o_valid && !i_stall;
    assign o_data   = r_q[r_rd];

    assign off_m5  = r_off - OFF_POS_FIRST;
    assign rb_m7   = r_rb - RB_T_POS_LO;
    assign lim_cur = (r_total < MAX_ANCHORS) ? r_total : MAX_ANCHORS;

    // per-byte parse and next state
    always_comb begin
        n_off   = (r_off < OFF_MAX) ? r_off + 9'd1 : r_off;
        n_dtype = r_dtype;
        n_total = r_total;
        n_idx   = r_idx;
        n_rb    = r_rb;
        n_id    = r_id;
        n_rng   = r_rng;
        n_coord = r_coord;
        n_qhold = r_qhold;
        n_err   = r_err;
        n_self  = r_self;
        rec_vld = 1'b0;
        rec     = '0;
        ci      = 2'd0;
        lim_next = '0;
        st      = ST_OK;
        sts     = '0;

        if (r_off == OFF_POS_TYPE) begin
            n_self = (b == TYPE_POS);
        end else if (r_off >= OFF_POS_FIRST && r_off <= OFF_POS_LAST) begin
            ci = off_m5[3:2];
            n_coord[ci] = {b, r_coord[ci][31:8]};
        end else if (r_off == OFF_POS_QUAL) begin
            if (r_self) begin
                rec_vld          = 1'b1;
                rec.record_kind  = KIND_SELF;
                rec.pos_x        = r_coord[0];
                rec.pos_y        = r_coord[1];
                rec.pos_z        = r_coord[2];
                rec.pos_quality  = b;
            end
        end else if (r_off == OFF_DIST_TYPE) begin
            if (b == TYPE_DIST) begin
                n_dtype = DT_ANCHOR;
            end else if (b == TYPE_POSDIST) begin
                n_dtype = DT_TAG;
            end else begin
                n_dtype = DT_UNKNOWN;
                n_err   = ST_BAD_TYPE;
            end
        end else if (r_off == OFF_COUNT) begin
            n_total = b;
            if (b > MAX_ANCHORS && r_err == ST_OK) begin
                n_err = ST_TOO_MANY;
            end
        end else if (r_off >= OFF_REC_START && (r_dtype == DT_ANCHOR || r_dtype == DT_TAG)
                     && r_idx < lim_cur) begin
            // identifier low bytes
            if (r_rb < RB_ID_END) begin
                if (r_rb == 5'd0) begin
                    n_id = {8'd0, b};
                end else begin
                    n_id = {b, r_id[7:0]};
                end
            end
            n_rb = r_rb + 5'd1;
            if (r_dtype == DT_ANCHOR) begin
                if (r_rb >= RB_A_RNG_LO && r_rb <= RB_A_RNG_HI) begin
                    n_rng = {b, r_rng[31:8]};
                end else if (r_rb == RB_A_QUAL) begin
                    rec_vld           = 1'b1;
                    rec.record_kind   = KIND_ANCHOR;
                    rec.node_id       = r_id;
                    rec.range_mm      = r_rng;
                    rec.range_quality = b;
                end
            end else begin
                if (r_rb >= RB_T_RNG_LO && r_rb <= RB_T_RNG_HI) begin
                    n_rng = {b, r_rng[31:8]};
                end else if (r_rb == RB_T_RQUAL) begin
                    n_qhold = b;
                end else if (r_rb >= RB_T_POS_LO && r_rb <= RB_T_POS_HI) begin
                    ci = rb_m7[3:2];
                    n_coord[ci] = {b, r_coord[ci][31:8]};
                end else if (r_rb == RB_T_PQUAL) begin
                    rec_vld           = 1'b1;
                    rec.record_kind   = KIND_TAG;
                    rec.node_id       = r_id;
                    rec.range_mm      = r_rng;
                    rec.range_quality = r_qhold;
                    rec.pos_x         = r_coord[0];
                    rec.pos_y         = r_coord[1];
                    rec.pos_z         = r_coord[2];
                    rec.pos_quality   = b;
                end
            end
            // record complete
            if (rec_vld) begin
                n_rb  = 5'd0;
                n_idx = r_idx + 8'd1;
            end
        end
        rec.last_of_run = !i_data.frame_end;

        // frame status from the updated state
        lim_next = (n_total < MAX_ANCHORS) ? n_total : MAX_ANCHORS;
        if (r_off < OFF_COUNT) begin
            st = ST_SHORT;
        end else if (n_err == ST_BAD_TYPE) begin
            st = ST_BAD_TYPE;
        end else if (n_rb != 5'd0 || n_idx < lim_next) begin
            st = ST_TRUNCATED;
        end else if (n_err == ST_TOO_MANY) begin
            st = ST_TOO_MANY;
        end else begin
            st = ST_OK;
        end
        sts.record_kind  = KIND_STATUS;
        sts.frame_status = st;
        sts.last_of_run  = 1'b1;

        // frame end returns everything to reset
        if (i_data.frame_end) begin
            n_off   = '0;
            n_dtype = DT_NONE;
            n_total = '0;
            n_idx   = '0;
            n_rb    = '0;
            n_id    = '0;
            n_rng   = '0;
            for (int i = 0; i < 3; i++) begin
                n_coord[i] = '0;
            end
            n_qhold = '0;
            n_err   = ST_OK;
            n_self  = 1'b0;
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_dtype <= DT_NONE;
            r_total <= '0;
            r_idx   <= '0;
            r_rb    <= '0;
            r_id    <= '0;
            r_rng   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_coord[i] <= '0;
            end
            r_qhold <= '0;
            r_err   <= ST_OK;
            r_self  <= 1'b0;
        end else if (in_xfer) begin
            r_off   <= n_off;
            r_dtype <= n_dtype;
            r_total <= n_total;
            r_idx   <= n_idx;
            r_rb    <= n_rb;
            r_id    <= n_id;
            r_rng   <= n_rng;
            r_coord <= n_coord;
            r_qhold <= n_qhold;
            r_err   <= n_err;
            r_self  <= n_self;
        end
    end

    // result queue payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (rec_vld) begin
                r_q[r_wr] <= rec;
                if (i_data.frame_end) begin
                    r_q[r_wr + 2'd1] <= sts;
                end
            end else if (i_data.frame_end) begin
                r_q[r_wr] <= sts;
            end
        end
    end

    // result queue pointers and fill count
    logic [1:0] push_n;
    assign push_n = in_xfer ? ({1'b0, rec_vld} + {1'b0, i_data.frame_end}) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + push_n;
            r_rd  <= r_rd + {1'b0, out_xfer};
            r_cnt <= r_cnt + {1'b0, push_n} - {2'b0, out_xfer};
        end
    end

endmodule

@@ sv/ltfp_checker.sv @@
// checker: port-level assertions on the location tlv frame parser, bound to the top level
module ltfp_checker
    import ltfp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped while stalled");

    // a stalled result does not change
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("result changed while stalled");

    // status record always closes its run
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.record_kind == KIND_STATUS |-> o_data.last_of_run)
        else $error("status record without last_of_run");

    // only status records carry a status code
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.record_kind != KIND_STATUS |-> o_data.frame_status == ST_OK)
        else $error("non-status record with nonzero status");

    // a frame-ending byte transfer yields a result on the next cycle
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.frame_end |=> o_valid)
        else $error("no result after frame end");

endmodule

bind location_tlv_frame_parser_unit ltfp_checker u_ltfp_checker (.*);

@@ tb/sv/tb.sv @@
// testbench: location tlv frame parser driven with directed and random frames, self-checking
`timescale 1ns / 100ps

module tb;
    import ltfp_pkg::*;

    // content patterns for the bytes of a frame
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;
    localparam int FILL_EDGES  = 3;

    // quiet cycles before the run is declared hung
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 100;
    localparam int PHASE_BYTES = 40;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int bytes_sent   = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;
    bit in_took      = 1'b0;
    bit out_took     = 1'b0;

    // predicts the records of the parser and matches them against the output
    class record_predictor;
        logic [8:0]  byte_pos;
        logic [1:0]  dist_kind;
        logic [7:0]  anchor_count;
        logic [7:0]  anchors_done;
        logic [4:0]  rec_pos;
        logic [15:0] id_acc;
        logic [31:0] range_acc;
        logic [31:0] coord_acc [3];
        logic [7:0]  rq_hold;
        logic [2:0]  frame_err;
        bit          has_self;
        t_out_item   expected_records [$];
        int          mismatches;

        function new();
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos     = '0;
            dist_kind    = DT_NONE;
            anchor_count = '0;
            anchors_done = '0;
            rec_pos      = '0;
            id_acc       = '0;
            range_acc    = '0;
            coord_acc    = '{default: '0};
            rq_hold      = '0;
            frame_err    = ST_OK;
            has_self     = 1'b0;
        endfunction

        function logic [7:0] record_limit();
            return (anchor_count < MAX_ANCHORS) ? anchor_count : MAX_ANCHORS;
        endfunction

        // one accepted byte: update the frame state, queue the records it completes
        function void note_byte(t_in_item it);
            logic [7:0] b;
            logic [8:0] off;
            logic [4:0] rp;
            int         cix;
            bit         done;
            t_out_item  rec;
            t_out_item  made [$];
            b    = it.data_byte;
            off  = byte_pos;
            done = 1'b0;
            if (off == 9'd3) begin
                has_self = (b == TYPE_POS);
            end else if (off >= 9'd5 && off <= 9'd16) begin
                cix = (off - 5) / 4;
                coord_acc[cix] = {b, coord_acc[cix][31:8]};
            end else if (off == 9'd17) begin
                if (has_self) begin
                    rec             = '0;
                    rec.record_kind = KIND_SELF;
                    rec.pos_x       = coord_acc[0];
                    rec.pos_y       = coord_acc[1];
                    rec.pos_z       = coord_acc[2];
                    rec.pos_quality = b;
                    made.push_back(rec);
                end
            end else if (off == 9'd18) begin
                if (b == TYPE_DIST) begin
                    dist_kind = DT_ANCHOR;
                end else if (b == TYPE_POSDIST) begin
                    dist_kind = DT_TAG;
                end else begin
                    dist_kind = DT_UNKNOWN;
                    frame_err = ST_BAD_TYPE;
                end
            end else if (off == 9'd20) begin
                anchor_count = b;
                if (b > MAX_ANCHORS && frame_err == ST_OK) frame_err = ST_TOO_MANY;
            end else if (off >= 9'd21 && (dist_kind == DT_ANCHOR || dist_kind == DT_TAG)
                         && anchors_done < record_limit()) begin
                rp = rec_pos;
                if (rp == 5'd0) begin
                    id_acc = {8'd0, b};
                end else if (rp == 5'd1) begin
                    id_acc = {b, id_acc[7:0]};
                end
                if (dist_kind == DT_ANCHOR) begin
                    // 8-byte id, 4-byte distance, quality
                    if (rp >= 5'd8 && rp <= 5'd11) begin
                        range_acc = {b, range_acc[31:8]};
                    end else if (rp == 5'd12) begin
                        rec               = '0;
                        rec.record_kind   = KIND_ANCHOR;
                        rec.node_id       = id_acc;
                        rec.range_mm      = range_acc;
                        rec.range_quality = b;
                        made.push_back(rec);
                        done = 1'b1;
                    end
                end else begin
                    // 2-byte id, distance, quality, three coordinates, position quality
                    if (rp >= 5'd2 && rp <= 5'd5) begin
                        range_acc = {b, range_acc[31:8]};
                    end else if (rp == 5'd6) begin
                        rq_hold = b;
                    end else if (rp >= 5'd7 && rp <= 5'd18) begin
                        cix = (rp - 7) / 4;
                        coord_acc[cix] = {b, coord_acc[cix][31:8]};
                    end else if (rp == 5'd19) begin
                        rec               = '0;
                        rec.record_kind   = KIND_TAG;
                        rec.node_id       = id_acc;
                        rec.range_mm      = range_acc;
                        rec.range_quality = rq_hold;
                        rec.pos_x         = coord_acc[0];
                        rec.pos_y         = coord_acc[1];
                        rec.pos_z         = coord_acc[2];
                        rec.pos_quality   = b;
                        made.push_back(rec);
                        done = 1'b1;
                    end
                end
                if (done) begin
                    rec_pos      = '0;
                    anchors_done = anchors_done + 8'd1;
                end else begin
                    rec_pos = rp + 5'd1;
                end
            end

            if (byte_pos != 9'd511) byte_pos = byte_pos + 9'd1;

            // status record closes the frame
            if (it.frame_end) begin
                rec             = '0;
                rec.record_kind = KIND_STATUS;
                if (off < 9'd20) begin
                    rec.frame_status = ST_SHORT;
                end else if (frame_err == ST_BAD_TYPE) begin
                    rec.frame_status = ST_BAD_TYPE;
                end else if (rec_pos != 5'd0 || anchors_done < record_limit()) begin
                    rec.frame_status = ST_TRUNCATED;
                end else if (frame_err == ST_TOO_MANY) begin
                    rec.frame_status = ST_TOO_MANY;
                end else begin
                    rec.frame_status = ST_OK;
                end
                made.push_back(rec);
                clear_frame();
            end

            if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
            foreach (made[i]) expected_records.push_back(made[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // one accepted record against the oldest expected one
        function void check_record(t_out_item got);
            t_out_item want;
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected record, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_records.pop_front();
            compare_field("record_kind", want.record_kind, got.record_kind);
            compare_field("node_id", want.node_id, got.node_id);
            compare_field("range_mm", want.range_mm, got.range_mm);
            compare_field("range_quality", want.range_quality, got.range_quality);
            compare_field("pos_x", want.pos_x, got.pos_x);
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("pos_z", want.pos_z, got.pos_z);
            compare_field("pos_quality", want.pos_quality, got.pos_quality);
            compare_field("frame_status", want.frame_status, got.frame_status);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    record_predictor sb;

    location_tlv_frame_parser_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // sample both channels mid-cycle; a transfer completes at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            in_took  = i_valid && !o_stall;
            out_took = o_valid && !i_stall;
            if (out_took) sb.check_record(o_data);
            if (in_took) sb.note_byte(i_data);
            quiet_cycles = (in_took || out_took) ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("tb failed");
        $finish;
    end

    // receiver: random stall, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic logic [7:0] fill_byte(int mode);
        case (mode)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            FILL_EDGES: begin
                case ($urandom_range(3))
                    0: return 8'h00;
                    1: return 8'hFF;
                    2: return 8'h80;
                    default: return 8'h7F;
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one byte transfer, with idle cycles in front, each drawn with the idle percentage
    task automatic send_byte(input logic [7:0] b, input bit fin);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, frame_end: fin};
        do @(posedge i_clk); while (!in_took);
        bytes_sent++;
    endtask

    // frame of len bytes with the type bytes and anchor count in place
    task automatic send_frame(input bit self_on, input logic [7:0] dt, input logic [7:0] cnt,
                              input int len, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = fill_byte(fill);
            if (i == 3) b = self_on ? TYPE_POS : (b == TYPE_POS ? 8'h00 : b);
            if (i == 18) b = dt;
            if (i == 20) b = cnt;
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] dt;
        logic [7:0] cnt;
        int         r;
        int         rec_len;
        int         full;
        int         len;
        int         fill;
        r = $urandom_range(99);
        if (r < 45) dt = TYPE_DIST;
        else if (r < 90) dt = TYPE_POSDIST;
        else dt = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 75) cnt = 8'($urandom_range(0, 3));
        else if (r < 92) cnt = 8'($urandom_range(4, 14));
        else cnt = 8'($urandom_range(15, 255));
        rec_len = (dt == TYPE_DIST) ? 13 : (dt == TYPE_POSDIST) ? 20 : 0;
        full = 21 + rec_len * ((cnt < MAX_ANCHORS) ? int'(cnt) : int'(MAX_ANCHORS));
        // mostly complete frames, some cut inside the records, a few short ones
        r = $urandom_range(99);
        if (r < 75) len = full + (($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0);
        else if (r < 90) len = (full > 21) ? $urandom_range(21, full - 1) : full;
        else len = $urandom_range(1, 20);
        fill = ($urandom_range(99) < 80) ? FILL_RANDOM : $urandom_range(FILL_ZERO, FILL_EDGES);
        send_frame(1'($urandom_range(1)), dt, cnt, len, fill);
    endtask

    // sender pause until the parser has delivered everything
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.expected_records.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        int start;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames, no idling
        send_frame(1, TYPE_DIST, 8'd0, 1, FILL_RANDOM);                 // single byte frame
        send_frame(1, TYPE_DIST, 8'd0, 18, FILL_ONES);                  // self position and end together
        send_frame(1, TYPE_DIST, 8'd0, 20, FILL_ZERO);                  // ends just before the count
        send_frame(0, 8'h13, 8'd0, 19, FILL_RANDOM);                    // short beats bad type
        send_frame(0, TYPE_DIST, 8'd0, 21, FILL_RANDOM);                // shortest valid frame
        send_frame(1, TYPE_DIST, 8'd2, 21 + 2 * 13, FILL_EDGES);        // anchor records, last on end
        send_frame(1, TYPE_POSDIST, 8'd3, 21 + 3 * 20 + 4, FILL_ONES);  // tag records, trailing bytes
        send_frame(0, 8'h00, 8'd3, 40, FILL_RANDOM);                    // unknown distance type
        send_frame(0, 8'hFF, 8'd20, 30, FILL_RANDOM);                   // bad type beats too many
        send_frame(1, TYPE_POSDIST, 8'd2, 21 + 20 + 7, FILL_RANDOM);    // cut inside a record
        send_frame(0, TYPE_DIST, 8'd3, 21 + 2 * 13, FILL_RANDOM);       // cut between records
        send_frame(0, TYPE_DIST, 8'd15, 21 + 14 * 13 + 5, FILL_EDGES);  // too many anchors
        send_frame(1, TYPE_POSDIST, 8'd255, 21 + 20, FILL_RANDOM);      // too many, but cut short
        send_frame(0, TYPE_DIST, 8'd1, 520, FILL_RANDOM);               // offset runs past its ceiling
        wait_drained();

        // long receiver hold-off while a record-heavy frame keeps coming
        @(negedge i_clk);
        hold_req = 1'b1;
        @(posedge i_clk);
        send_frame(0, TYPE_DIST, MAX_ANCHORS, 21 + 14 * 13, FILL_RANDOM);
        wait_drained();

        // random frames under four idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) send_random_frame();
        end

        i_valid <= 1'b0;
        while (sb.expected_records.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_records.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
